// File: hdl/front_middle_back_queue_core_defines.svh
// Assertion macros used by the checker file.
`ifndef FRONT_MIDDLE_BACK_QUEUE_CORE_DEFINES_SVH
`define FRONT_MIDDLE_BACK_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FMBQ_ASSERT_IMPL(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FMBQ_ASSERT_NEXT(name, clk, rst_n, pre, post) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");

`endif

// File: hdl/fmbq_pkg.sv
// Types and constants shared by the front/middle/back queue modules.
package fmbq_pkg;

	localparam int CMD_W   = 3;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT  = 3'd0,
		CMD_PUSH_MIDDLE = 3'd1,
		CMD_PUSH_BACK   = 3'd2,
		CMD_POP_FRONT   = 3'd3,
		CMD_POP_MIDDLE  = 3'd4,
		CMD_POP_BACK    = 3'd5
	} cmd_e_t;

	// Shift control broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic rem;
	} fmbq_op_t;

	// Status of one transaction.
	typedef struct packed {
		logic empty;
		logic full;
	} fmbq_flag_t;

endpackage

// File: hdl/fmbq_ifs.sv
// Valid/ready channel interfaces for commands and results.
interface fmbq_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [fmbq_pkg::CMD_W-1:0]          cmd;
	logic signed [fmbq_pkg::DATA_W-1:0]  value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

interface fmbq_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [fmbq_pkg::DATA_W-1:0]  popped_value;
	logic                                was_empty;
	logic                                was_full;
	logic [fmbq_pkg::COUNT_W-1:0]        count;

	modport source (output valid, output popped_value, output was_empty, output was_full,
		output count, input ready);
	modport sink (input valid, input popped_value, input was_empty, input was_full,
		input count, output ready);
endinterface

// File: hdl/front_middle_back_queue_core.sv
// Top level of the front/middle/back queue: control, cell row, result register.
// Bounded queue of CAPACITY signed 32-bit values with push and pop at the front, the
// middle (push at floor(count/2), pop at floor((count-1)/2)) and the back. Every
// command yields one registered result, captured on acceptance; a new command is taken every
// cycle while the result register is empty or being drained. Each cell is updated in
// the same cycle from its neighbor, so the fill counter and the cell row settle a
// command together, on the accepting edge. Count is the fill masked to 7 bits. No clearing pass at reset.
module front_middle_back_queue_core #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	fmbq_cmd_if.sink          req,
	fmbq_res_if.source        rsp
);
	import fmbq_pkg::*;

	localparam int PW = $clog2(CAPACITY);
	localparam int FW = $clog2(CAPACITY + 1);

	logic               fire;
	fmbq_op_t           op;
	logic [PW-1:0]      pos;
	fmbq_flag_t         flag;
	logic [FW-1:0]      fill_next;
	logic [DATA_W-1:0]  cell_data [CAPACITY];
	logic [DATA_W-1:0]  cell_sel  [CAPACITY];
	logic [DATA_W-1:0]  popped;

	logic               rsp_valid_q;
	logic [DATA_W-1:0]  popped_q;
	logic               empty_q;
	logic               full_q;
	logic [COUNT_W-1:0] count_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	fmbq_ctrl #(
		.CAPACITY (CAPACITY),
		.PW       (PW),
		.FW       (FW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.cmd       (req.cmd),
		.op        (op),
		.pos       (pos),
		.flag      (flag),
		.fill_next (fill_next)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left;
		logic [DATA_W-1:0] right;

		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = cell_data[i+1];
		end

		fmbq_cell #(
			.PW  (PW),
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.pos        (pos),
			.push_value ($unsigned(req.value)),
			.left       (left),
			.right      (right),
			.data       (cell_data[i]),
			.sel        (cell_sel[i])
		);
	end

	always_comb begin
		popped = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			popped = popped | cell_sel[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			popped_q <= popped;
			empty_q  <= flag.empty;
			full_q   <= flag.full;
			count_q  <= COUNT_W'(fill_next);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = $signed(popped_q);
	assign rsp.was_empty    = empty_q;
	assign rsp.was_full     = full_q;
	assign rsp.count        = count_q;

endmodule

// File: hdl/fmbq_cell.sv
// One storage cell of the queue: holds a value, shifts toward front or back.
module fmbq_cell #(
	parameter int PW  = 6,
	parameter int IDX = 0
) (
	input  logic                        clk,
	input  fmbq_pkg::fmbq_op_t          op,
	input  logic [PW-1:0]               pos,
	input  logic [fmbq_pkg::DATA_W-1:0] push_value,
	input  logic [fmbq_pkg::DATA_W-1:0] left,
	input  logic [fmbq_pkg::DATA_W-1:0] right,
	output logic [fmbq_pkg::DATA_W-1:0] data,
	output logic [fmbq_pkg::DATA_W-1:0] sel
);
	import fmbq_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic              hit;
	logic              after;

	assign hit   = (pos == PW'(IDX));
	assign after = (pos < PW'(IDX));

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (hit) begin
				data_q <= push_value;
			end else if (after) begin
				data_q <= left;
			end
		end else if (op.rem) begin
			if (hit || after) begin
				data_q <= right;
			end
		end
	end

	assign data = data_q;
	assign sel  = (op.rem && hit) ? data_q : '0;

endmodule

// File: hdl/fmbq_ctrl.sv
// Command decode, fill counter and shift position for the cell row.
module fmbq_ctrl #(
	parameter int CAPACITY = 64,
	parameter int PW       = 6,
	parameter int FW       = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [fmbq_pkg::CMD_W-1:0] cmd,
	output fmbq_pkg::fmbq_op_t         op,
	output logic [PW-1:0]              pos,
	output fmbq_pkg::fmbq_flag_t       flag,
	output logic [FW-1:0]              fill_next
);
	import fmbq_pkg::*;

	logic [FW-1:0] fill_q;
	logic          is_full;
	logic          is_empty;
	logic [FW-1:0] half;
	logic [FW-1:0] less1;
	logic [FW-1:0] less1_half;

	assign is_full    = (fill_q == FW'(CAPACITY));
	assign is_empty   = (fill_q == '0);
	assign half       = fill_q >> 1;
	assign less1      = fill_q - FW'(1);
	assign less1_half = less1 >> 1;

	always_comb begin
		op        = '0;
		pos       = '0;
		flag      = '0;
		fill_next = fill_q;
		unique case (cmd_e_t'(cmd))
			CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK: begin
				if (is_full) begin
					flag.full = 1'b1;
				end else begin
					op.ins    = fire;
					fill_next = fill_q + FW'(1);
					if (cmd_e_t'(cmd) == CMD_PUSH_MIDDLE) begin
						pos = PW'(half);
					end else if (cmd_e_t'(cmd) == CMD_PUSH_BACK) begin
						pos = PW'(fill_q);
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK: begin
				if (is_empty) begin
					flag.empty = 1'b1;
				end else begin
					op.rem    = fire;
					fill_next = less1;
					if (cmd_e_t'(cmd) == CMD_POP_MIDDLE) begin
						pos = PW'(less1_half);
					end else if (cmd_e_t'(cmd) == CMD_POP_BACK) begin
						pos = PW'(less1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (fire) begin
			fill_q <= fill_next;
		end
	end

endmodule

// File: hdl/fmbq_chk.sv
// Port-level checker for the front/middle/back queue, bound to the top level.
`include "front_middle_back_queue_core_defines.svh"

module fmbq_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_ready,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic signed [fmbq_pkg::DATA_W-1:0] popped_value,
	input logic                              was_empty,
	input logic                              was_full,
	input logic [fmbq_pkg::COUNT_W-1:0]      count
);
	import fmbq_pkg::*;

	`FMBQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(popped_value) && $stable(count))
	`FMBQ_ASSERT_IMPL(a_flags_excl, clk, arst_n, rsp_valid, !(was_empty && was_full))
	`FMBQ_ASSERT_IMPL(a_empty_res, clk, arst_n, rsp_valid && was_empty, count == '0 && popped_value == '0)
	`FMBQ_ASSERT_IMPL(a_full_res, clk, arst_n, rsp_valid && was_full, popped_value == '0)
	`FMBQ_ASSERT_IMPL(a_ready_idle, clk, arst_n, !rsp_valid, req_ready)

endmodule

bind front_middle_back_queue_core fmbq_chk u_fmbq_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.popped_value (rsp.popped_value),
	.was_empty    (rsp.was_empty),
	.was_full     (rsp.was_full),
	.count        (rsp.count)
);

// File: dv/tb_top.sv
// Self-checking testbench for the front/middle/back queue: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;
	import fmbq_pkg::*;

	localparam int DEPTH        = 64;
	localparam int RAND_ITEMS   = 1130;
	localparam int HOLD_CYCLES  = 300;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

	localparam logic signed [DATA_W-1:0] S32_MIN = 32'h8000_0000;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped;
		logic                     empty;
		logic                     full;
		logic [COUNT_W-1:0]       cnt;
	} qres_t;

	typedef struct {
		logic [CMD_W-1:0]         cmd;
		logic signed [DATA_W-1:0] value;
		bit                       typed;
		qres_t                    res;
	} step_row_t;

	logic clk;
	logic arst_n;

	fmbq_cmd_if req_if();
	fmbq_res_if rsp_if();

	front_middle_back_queue_core #(.CAPACITY(DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	logic signed [DATA_W-1:0] shadow_q[$];
	qres_t                    expected_results[$];
	step_row_t                dir_rows[$];
	bit                       cur_typed;
	qres_t                    cur_expect;
	int                       burst_left;
	int                       results_seen;
	int                       err_count;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void add_row(step_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic qres_t apply_cmd(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v);
		qres_t r;
		int    pos;
		r = '0;
		case (c)
			CMD_PUSH_FRONT, CMD_PUSH_MIDDLE, CMD_PUSH_BACK: begin
				if (shadow_q.size() >= DEPTH) begin
					r.full = 1'b1;
				end else begin
					if (c == CMD_PUSH_FRONT)
						pos = 0;
					else if (c == CMD_PUSH_MIDDLE)
						pos = shadow_q.size() / 2;
					else
						pos = shadow_q.size();
					shadow_q.insert(pos, v);
				end
			end
			CMD_POP_FRONT, CMD_POP_MIDDLE, CMD_POP_BACK: begin
				if (shadow_q.size() == 0) begin
					r.empty = 1'b1;
				end else begin
					if (c == CMD_POP_FRONT)
						pos = 0;
					else if (c == CMD_POP_MIDDLE)
						pos = (shadow_q.size() - 1) / 2;
					else
						pos = shadow_q.size() - 1;
					r.popped = shadow_q[pos];
					shadow_q.delete(pos);
				end
			end
			default: begin
			end
		endcase
		r.cnt = COUNT_W'(shadow_q.size());
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_value();
		case ($urandom_range(0, 11))
			0: return S32_MIN;
			1: return S32_MAX;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Drive one transaction at the falling edge; return at the falling edge after acceptance.
	task automatic offer(logic [CMD_W-1:0] c, logic signed [DATA_W-1:0] v, bit typed,
		qres_t res);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_if.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 24);
		end
		burst_left--;
		req_if.valid = 1'b1;
		req_if.cmd   = c;
		req_if.value = v;
		cur_typed    = typed;
		cur_expect   = res;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
	endtask

	// Predict on command acceptance, compare on result acceptance.
	always @(posedge clk) begin
		qres_t p;
		qres_t e;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				p = apply_cmd(req_if.cmd, req_if.value);
				expected_results.insert(expected_results.size(), cur_typed ? cur_expect : p);
			end
			if (rsp_if.valid && rsp_if.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("unexpected result transaction: count %0d", rsp_if.count);
					err_count++;
				end else begin
					e = expected_results[0];
					expected_results.delete(0);
					if (rsp_if.popped_value !== e.popped) begin
						$error("popped_value: expected %0d, got %0d", e.popped,
							rsp_if.popped_value);
						err_count++;
					end
					if (rsp_if.was_empty !== e.empty) begin
						$error("was_empty: expected %0b, got %0b", e.empty, rsp_if.was_empty);
						err_count++;
					end
					if (rsp_if.was_full !== e.full) begin
						$error("was_full: expected %0b, got %0b", e.full, rsp_if.was_full);
						err_count++;
					end
					if (rsp_if.count !== e.cnt) begin
						$error("count: expected %0d, got %0d", e.cnt, rsp_if.count);
						err_count++;
					end
				end
			end
		end
	end

	// Result side: changing stall patterns plus periodic long hold-offs.
	initial begin
		int               phase;
		int               mode;
		int               next_hold;
		logic [15:0]      pat;
		phase     = 0;
		mode      = 0;
		next_hold = 250;
		pat       = '1;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (results_seen >= next_hold) begin
				rsp_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				next_hold += 500;
			end
			if (phase == 0) begin
				mode = $urandom_range(0, 2);
				pat  = 16'($urandom);
			end
			phase = (phase + 1) % 48;
			case (mode)
				0: rsp_if.ready = 1'b1;
				1: rsp_if.ready = pat[phase % 16];
				default: rsp_if.ready = ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle = 0;
			else
				idle++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int               sent;
		int               mode;
		int               extra;
		int               k;
		logic [CMD_W-1:0] c;
		clk          = 1'b0;
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.cmd   = CMD_PUSH_FRONT;
		req_if.value = '0;
		cur_typed    = 1'b0;
		cur_expect   = '0;
		burst_left   = 0;
		results_seen = 0;
		err_count    = 0;
		sent         = 0;

		// cmd, value, typed, {popped, empty, full, count}
		add_row('{CMD_POP_FRONT,   32'sd17,      1'b1, '{'0, 1'b1, 1'b0, 7'd0}});
		add_row('{CMD_POP_MIDDLE,  S32_MIN,      1'b1, '{'0, 1'b1, 1'b0, 7'd0}});
		add_row('{CMD_POP_BACK,    S32_MAX,      1'b1, '{'0, 1'b1, 1'b0, 7'd0}});
		add_row('{CMD_RSVD_6,      '1,           1'b1, '{'0, 1'b0, 1'b0, 7'd0}});
		add_row('{CMD_PUSH_BACK,   S32_MAX,      1'b1, '{'0, 1'b0, 1'b0, 7'd1}});
		add_row('{CMD_PUSH_FRONT,  S32_MIN,      1'b1, '{'0, 1'b0, 1'b0, 7'd2}});
		add_row('{CMD_PUSH_MIDDLE, '1,           1'b1, '{'0, 1'b0, 1'b0, 7'd3}});
		add_row('{CMD_PUSH_MIDDLE, '0,           1'b1, '{'0, 1'b0, 1'b0, 7'd4}});
		add_row('{CMD_PUSH_BACK,   32'h55555555, 1'b0, '0});
		add_row('{CMD_PUSH_FRONT,  32'hAAAAAAAA, 1'b0, '0});
		add_row('{CMD_RSVD_7,      32'h12345678, 1'b1, '{'0, 1'b0, 1'b0, 7'd6}});
		add_row('{CMD_POP_MIDDLE,  '1,           1'b0, '0});
		add_row('{CMD_POP_MIDDLE,  S32_MIN,      1'b0, '0});
		add_row('{CMD_POP_FRONT,   '0,           1'b1,
			'{32'hAAAAAAAA, 1'b0, 1'b0, 7'd3}});
		add_row('{CMD_POP_BACK,    '1,           1'b1,
			'{32'h55555555, 1'b0, 1'b0, 7'd2}});
		add_row('{CMD_POP_MIDDLE,  32'sd5,       1'b0, '0});
		add_row('{CMD_POP_MIDDLE,  '0,           1'b1, '{S32_MAX, 1'b0, 1'b0, 7'd0}});
		add_row('{CMD_POP_MIDDLE,  '1,           1'b1, '{'0, 1'b1, 1'b0, 7'd0}});
		add_row('{CMD_PUSH_MIDDLE, 32'sd1,       1'b1, '{'0, 1'b0, 1'b0, 7'd1}});
		add_row('{CMD_POP_BACK,    '0,           1'b1, '{32'sd1, 1'b0, 1'b0, 7'd0}});

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].res);

		while (sent < RAND_ITEMS) begin
			mode = $urandom_range(0, 9);
			if (mode <= 2) begin
				// fill up to capacity, then push into the full queue a few times
				extra = $urandom_range(1, 6);
				while (extra > 0) begin
					if (shadow_q.size() >= DEPTH)
						extra--;
					if ($urandom_range(0, 9) == 0)
						c = CMD_W'($urandom_range(CMD_POP_FRONT, CMD_POP_BACK));
					else
						c = CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_PUSH_BACK));
					offer(c, rand_value(), 1'b0, '0);
					sent++;
				end
			end else if (mode <= 4) begin
				// drain to empty, then pop the empty queue a few times
				extra = $urandom_range(1, 6);
				while (extra > 0) begin
					if (shadow_q.size() == 0)
						extra--;
					if ($urandom_range(0, 9) == 0)
						c = CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_PUSH_BACK));
					else
						c = CMD_W'($urandom_range(CMD_POP_FRONT, CMD_POP_BACK));
					offer(c, rand_value(), 1'b0, '0);
					sent++;
				end
			end else begin
				k = $urandom_range(8, 60);
				repeat (k) begin
					if (mode == 9)
						c = CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_RSVD_7));
					else if ($urandom_range(0, 1) == 0)
						c = CMD_W'($urandom_range(CMD_PUSH_FRONT, CMD_PUSH_BACK));
					else
						c = CMD_W'($urandom_range(CMD_POP_FRONT, CMD_POP_BACK));
					offer(c, rand_value(), 1'b0, '0);
					sent++;
				end
			end
		end
		req_if.valid = 1'b0;

		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
